// ----- rtl/core/stsi_pkg.sv -----
// ----------------------------------------------------------------------------
// stsi_pkg
// shared types and constants of the sorted table insert and search core
// ----------------------------------------------------------------------------
package stsi_pkg;

	localparam int CAPACITY = 128;
	localparam int KEY_W    = 32;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 7;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ENTRY_W  = KEY_W + WORD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_ISSUE,
		S_INS_CHK,
		S_INS_PUT,
		S_LK_ISSUE,
		S_LK_CHK,
		S_DONE
	} state_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [WORD_W-1:0]       word;
	} entry_t;

	// stored key against item key
	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage

// ----- rtl/core/stsi_ram.sv -----
// ----------------------------------------------------------------------------
// stsi_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module stsi_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/stsi_cmp.sv -----
// ----------------------------------------------------------------------------
// stsi_cmp
// shared signed key comparator used by both insert and lookup walks
// ----------------------------------------------------------------------------
module stsi_cmp (
	input  logic signed [stsi_pkg::KEY_W-1:0] stored_key,
	input  logic signed [stsi_pkg::KEY_W-1:0] item_key,
	output stsi_pkg::cmp_res_t                res
);
	import stsi_pkg::*;

	always_comb begin
		res.lt = stored_key < item_key;
		res.eq = stored_key == item_key;
		res.gt = stored_key > item_key;
	end

endmodule

// ----- rtl/core/sorted_table_insert_search_core.sv -----
// ----------------------------------------------------------------------------
// sorted_table_insert_search_core
// sorted key table with shifting insert and binary search lookup
// ----------------------------------------------------------------------------
// latency, accept to result valid, follows the walk: an insert into an empty table writes the
// item with no read, a full table rejects the item with no walk, any other insert moves each entry
// it passes up by one place; a lookup ends on the first probe that hits or when its range is empty
// one item at a time, set by the single ram port pair and the one shared comparator;
// the next item is taken the cycle after the result is loaded, even while it waits
// reset clears the entry count and handshake state; storage is not cleared
module sorted_table_insert_search_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic signed [stsi_pkg::KEY_W-1:0] key,
	input  logic [stsi_pkg::WORD_W-1:0]       payload,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [stsi_pkg::POS_W-1:0]        position,
	output logic [stsi_pkg::WORD_W-1:0]       stored_word,
	output logic                              table_full
);
	import stsi_pkg::*;

	// control state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;

	// latched item
	logic signed [KEY_W-1:0] key_q;
	logic [WORD_W-1:0]       pay_q;

	// walk registers
	logic [IDX_W-1:0] j_q;      // insert: entry being examined, moving down
	logic             first_q;  // insert: first probe is the last entry
	logic [CNT_W-1:0] lo_q;     // lookup: lowest candidate
	logic [CNT_W-1:0] hip_q;    // lookup: one above highest candidate
	logic [IDX_W-1:0] mid_q;

	// pending result and output register
	logic              res_found_q, res_full_q;
	logic [IDX_W-1:0]  res_pos_q;
	logic [WORD_W-1:0] res_word_q;
	logic              found_q, full_q;
	logic [IDX_W-1:0]  pos_q;
	logic [WORD_W-1:0] word_q;

	// ram side
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr;
	entry_t             ram_wdata, ram_rdata, new_entry;
	logic [ENTRY_W-1:0] ram_rdata_raw;
	cmp_res_t           cmp;

	logic             accept, is_full, is_last, shift, search_open, out_load;
	logic [CNT_W:0]   mid_sum;
	logic [IDX_W-1:0] mid_c;

	stsi_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ENTRY_W'(ram_wdata)),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	// one comparator serves the insert walk and every lookup probe
	stsi_cmp u_cmp (
		.stored_key(ram_rdata.key),
		.item_key  (key_q),
		.res       (cmp)
	);

	assign accept    = in_valid && in_ready;
	assign is_full   = count_q >= CNT_W'(CAPACITY);
	assign is_last   = j_q == '0;
	assign new_entry = '{key: key_q, word: pay_q};

	// the first probe (last entry) keeps equal keys below the new item,
	// deeper probes move equal keys up so the item lands before them
	assign shift = cmp.gt || (!first_q && cmp.eq);

	// bisection midpoint, (lo + hi) / 2 with hi = hip - 1
	assign search_open = lo_q < hip_q;
	assign mid_sum     = {1'b0, lo_q} + {1'b0, hip_q} - 1'b1;
	assign mid_c       = IDX_W'(mid_sum >> 1);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action_t'(action) == ACT_LOOKUP) begin
						state_d = S_LK_ISSUE;
					end else if (is_full) begin
						state_d = S_DONE;
					end else if (count_q == '0) begin
						state_d = S_INS_PUT;
					end else begin
						state_d = S_INS_ISSUE;
					end
				end
			end
			S_INS_ISSUE: state_d = S_INS_CHK;
			S_INS_CHK: begin
				if (!shift) begin
					state_d = S_DONE;
				end else if (is_last) begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT:  state_d = S_DONE;
			S_LK_ISSUE: state_d = search_open ? S_LK_CHK : S_DONE;
			S_LK_CHK:   state_d = cmp.eq ? S_DONE : S_LK_ISSUE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = new_entry;
		ram_raddr = j_q;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_INS_ISSUE: ram_raddr = j_q;
			S_INS_CHK: begin
				// move the entry up, or drop the item just above it
				ram_we    = 1'b1;
				ram_waddr = j_q + 1'b1;
				ram_wdata = shift ? ram_rdata : new_entry;
				ram_raddr = j_q - 1'b1;
			end
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
			end
			S_LK_ISSUE: ram_raddr = mid_c;
			S_LK_CHK, S_DONE: ram_raddr = j_q;
			default: ram_raddr = j_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new item is written exactly once per accepted insert that finds room
			if ((state_q == S_INS_CHK && !shift) || state_q == S_INS_PUT) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q       <= key;
					pay_q       <= payload;
					j_q         <= (count_q == '0) ? '0 : IDX_W'(count_q - 1'b1);
					first_q     <= 1'b1;
					lo_q        <= '0;
					hip_q       <= count_q;
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
					res_word_q  <= '0;
					res_full_q  <= (action_t'(action) == ACT_INSERT) && is_full;
				end
			end
			S_INS_CHK: begin
				first_q <= 1'b0;
				if (shift) begin
					if (!is_last) begin
						j_q <= j_q - 1'b1;
					end
				end else begin
					res_found_q <= 1'b1;
					res_pos_q   <= j_q + 1'b1;
				end
			end
			S_INS_PUT: begin
				res_found_q <= 1'b1;
				res_pos_q   <= j_q;
			end
			S_LK_ISSUE: mid_q <= mid_c;
			S_LK_CHK: begin
				priority if (cmp.eq) begin
					res_found_q <= 1'b1;
					res_pos_q   <= mid_q;
					res_word_q  <= ram_rdata.word;
				end else if (cmp.gt) begin
					hip_q <= CNT_W'(mid_q);
				end else begin
					lo_q <= CNT_W'(mid_q) + 1'b1;
				end
			end
			S_INS_ISSUE, S_DONE: begin
			end
			default: begin
			end
		endcase
		if (out_load) begin
			found_q <= res_found_q;
			pos_q   <= res_pos_q;
			word_q  <= res_word_q;
			full_q  <= res_full_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign position    = POS_W'(pos_q);
	assign stored_word = word_q;
	assign table_full  = full_q;

	// the entry count never passes the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// writes stay inside the filled part of the table plus one
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> CNT_W'(ram_waddr) <= count_q)
		else $error("table write beyond fill level");

	// every lookup probe reads a filled entry
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LK_CHK) |-> CNT_W'(mid_q) < count_q)
		else $error("lookup probe beyond fill level");

	// lookups leave the table size alone
	a_lookup_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LK_ISSUE || state_q == S_LK_CHK) |=> $stable(count_q))
		else $error("entry count changed during lookup");

	// a rejected insert reports nothing else
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> (!found && position == '0 && stored_word == '0))
		else $error("rejected insert with result fields set");

endmodule
